// ===== rtl/core/pbsr_pkg.sv =====
package pbsr_pkg;

  localparam int unsigned MHZ_W   = 13;
  localparam int unsigned KHZ_W   = 16;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned SCALE_W = 3;
  localparam int unsigned MULT_W  = 7;
  localparam int unsigned PROD_W  = 23;
  localparam int unsigned MM_W    = 20;
  localparam int unsigned QUOT_W  = 14;
  localparam int unsigned FRAC_W  = 10;
  localparam int unsigned INT_W   = 21;

  // Division by one thousand as a multiply by ceil(2^33 / 1000) and a shift.
  // Exact for every dividend below 2^23.
  localparam int unsigned RECIP_W     = 24;
  localparam int unsigned RECIP_SHIFT = 33;
  localparam int unsigned RECIP_PW    = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 24'd8589935;
  localparam logic [PROD_W-1:0]  THOUSAND  = 23'd1000;

  localparam logic [WORD_W-1:0] RESET_WORD_ONE   = 32'h0800_9F41;
  localparam logic [WORD_W-1:0] RESET_WORD_TWO   = 32'h0102_8E42;
  localparam logic [WORD_W-1:0] RESET_WORD_THREE = 32'h0000_04B3;
  localparam logic [WORD_W-1:0] RESET_WORD_FIVE  = 32'h0058_0005;
  localparam logic [SCALE_W-1:0] RESET_SCALE     = 3'd2;

  localparam logic [MHZ_W-1:0] EDGE_DIV8 = 13'd275;
  localparam logic [MHZ_W-1:0] EDGE_DIV4 = 13'd550;
  localparam logic [MHZ_W-1:0] EDGE_DIV2 = 13'd1100;
  localparam logic [MHZ_W-1:0] EDGE_DIV1 = 13'd2200;

  typedef enum logic [2:0] {
    REG_WORD_ONE   = 3'd0,
    REG_WORD_TWO   = 3'd1,
    REG_WORD_THREE = 3'd2,
    REG_WORD_FIVE  = 3'd3,
    REG_PFD_SCALE  = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    BAND_DIV16 = 3'd0,
    BAND_DIV8  = 3'd1,
    BAND_DIV4  = 3'd2,
    BAND_DIV2  = 3'd3,
    BAND_DIV1  = 3'd4
  } band_t;

  localparam logic [IDX_W-1:0] IDX_WORD5    = 3'd0;
  localparam logic [IDX_W-1:0] IDX_WORD4    = 3'd1;
  localparam logic [IDX_W-1:0] IDX_WORD3    = 3'd2;
  localparam logic [IDX_W-1:0] IDX_WORD2    = 3'd3;
  localparam logic [IDX_W-1:0] IDX_WORD1    = 3'd4;
  localparam logic [IDX_W-1:0] IDX_WORD0    = 3'd5;
  localparam logic [IDX_W-1:0] IDX_COMPUTED = 3'd6;

  typedef struct packed {
    logic [WORD_W-1:0] word_one;
    logic [WORD_W-1:0] word_two;
    logic [WORD_W-1:0] word_three;
    logic [WORD_W-1:0] word_five;
  } cfg_words_t;

  function automatic band_t pick_band(input logic [MHZ_W-1:0] mhz);
    band_t b;
    if (mhz < EDGE_DIV8) begin
      b = BAND_DIV16;
    end else if (mhz < EDGE_DIV4) begin
      b = BAND_DIV8;
    end else if (mhz < EDGE_DIV2) begin
      b = BAND_DIV4;
    end else if (mhz < EDGE_DIV1) begin
      b = BAND_DIV2;
    end else begin
      b = BAND_DIV1;
    end
    return b;
  endfunction

  function automatic logic [MULT_W-1:0] band_mult(input band_t b,
                                                  input logic [SCALE_W-1:0] scale);
    logic [MULT_W-1:0] s;
    s = MULT_W'(scale);
    case (b)
      BAND_DIV16: band_mult = s << 4;
      BAND_DIV8:  band_mult = s << 3;
      BAND_DIV4:  band_mult = s << 2;
      BAND_DIV2:  band_mult = s << 1;
      default:    band_mult = s;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] band_word4(input band_t b);
    case (b)
      BAND_DIV16: band_word4 = 32'h00C0_4024;
      BAND_DIV8:  band_word4 = 32'h00B0_4024;
      BAND_DIV4:  band_word4 = 32'h00A0_4024;
      BAND_DIV2:  band_word4 = 32'h0090_4024;
      default:    band_word4 = 32'h0080_4024;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] band_word0(input band_t b);
    case (b)
      BAND_DIV16: band_word0 = 32'h0FA0_0000;
      BAND_DIV8:  band_word0 = 32'h0FA0_0000;
      BAND_DIV4:  band_word0 = 32'h0FA0_0000;
      BAND_DIV2:  band_word0 = 32'h1068_0000;
      default:    band_word0 = 32'h08FC_0000;
    endcase
  endfunction

endpackage

// ===== rtl/core/pbsr_cfg.sv =====
module pbsr_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [pbsr_pkg::WORD_W-1:0] cfg_data,
  output pbsr_pkg::cfg_words_t        words,
  output logic [pbsr_pkg::SCALE_W-1:0] scale
);
  import pbsr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      words.word_one   <= RESET_WORD_ONE;
      words.word_two   <= RESET_WORD_TWO;
      words.word_three <= RESET_WORD_THREE;
      words.word_five  <= RESET_WORD_FIVE;
      scale            <= RESET_SCALE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WORD_ONE:   words.word_one   <= cfg_data;
        REG_WORD_TWO:   words.word_two   <= cfg_data;
        REG_WORD_THREE: words.word_three <= cfg_data;
        REG_WORD_FIVE:  words.word_five  <= cfg_data;
        REG_PFD_SCALE:  scale            <= cfg_data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/pbsr_calc.sv =====
module pbsr_calc (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [pbsr_pkg::SCALE_W-1:0] scale,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pbsr_pkg::MHZ_W-1:0]   freq_mhz,
  input  logic [pbsr_pkg::KHZ_W-1:0]   freq_khz,
  output logic                         out_valid,
  input  logic                         out_ready,
  output pbsr_pkg::band_t              out_band,
  output logic [pbsr_pkg::WORD_W-1:0]  out_word0
);
  import pbsr_pkg::*;

  logic               s1_valid;
  logic [MHZ_W-1:0]   s1_mhz;
  logic [KHZ_W-1:0]   s1_khz;
  logic               s2_valid;
  band_t              s2_band;
  logic [PROD_W-1:0]  s2_prod;
  logic [MM_W-1:0]    s2_mm;
  logic               s3_valid;
  band_t              s3_band;
  logic [PROD_W-1:0]  s3_prod;
  logic [MM_W-1:0]    s3_mm;
  logic [QUOT_W-1:0]  s3_quot;

  logic               en1;
  logic               en2;
  logic               en3;
  band_t              s1_band;
  logic [MULT_W-1:0]  s1_mult;
  logic [RECIP_PW-1:0] recip_prod;
  logic [INT_W-1:0]   integer_part;
  logic [PROD_W-1:0]  quot_k;
  logic [FRAC_W-1:0]  fraction;

  assign en3      = !s3_valid || out_ready;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;

  assign s1_band    = pick_band(s1_mhz);
  assign s1_mult    = band_mult(s1_band, scale);
  assign recip_prod = RECIP_PW'(s2_prod) * RECIP_PW'(RECIP_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid <= in_valid;
      end
      if (en2) begin
        s2_valid <= s1_valid;
      end
      if (en3) begin
        s3_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      s1_mhz <= freq_mhz;
      s1_khz <= freq_khz;
    end
    if (en2 && s1_valid) begin
      s2_band <= s1_band;
      s2_prod <= PROD_W'(s1_mult) * PROD_W'(s1_khz);
      s2_mm   <= MM_W'(s1_mult) * MM_W'(s1_mhz);
    end
    if (en3 && s2_valid) begin
      s3_band <= s2_band;
      s3_prod <= s2_prod;
      s3_mm   <= s2_mm;
      s3_quot <= recip_prod[RECIP_PW-1:RECIP_SHIFT];
    end
  end

  assign integer_part = INT_W'(s3_mm) + INT_W'(s3_quot);
  assign quot_k       = PROD_W'(s3_quot) * THOUSAND;
  assign fraction     = FRAC_W'(s3_prod - quot_k);

  assign out_valid = s3_valid;
  assign out_band  = s3_band;
  assign out_word0 = {integer_part[16:0], 15'd0} + {19'd0, fraction, 3'd0};

endmodule

// ===== rtl/core/pbsr_seq.sv =====
module pbsr_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  pbsr_pkg::cfg_words_t        words,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  pbsr_pkg::band_t             in_band,
  input  logic [pbsr_pkg::WORD_W-1:0] in_word0,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [pbsr_pkg::WORD_W-1:0] m_axis_tdata,
  output logic [pbsr_pkg::IDX_W-1:0]  m_axis_tuser,
  output logic                        m_axis_tlast
);
  import pbsr_pkg::*;

  logic              active;
  band_t             band;
  logic [WORD_W-1:0] word0;
  logic [IDX_W-1:0]  idx;
  logic              out_load;
  logic              finishing;
  logic [WORD_W-1:0] sel_word;

  assign out_load  = active && (!m_axis_tvalid || m_axis_tready);
  assign finishing = out_load && (idx == IDX_COMPUTED);
  assign in_ready  = !active || finishing;

  always_comb begin
    case (idx)
      IDX_WORD5: sel_word = words.word_five;
      IDX_WORD4: sel_word = band_word4(band);
      IDX_WORD3: sel_word = words.word_three;
      IDX_WORD2: sel_word = words.word_two;
      IDX_WORD1: sel_word = words.word_one;
      IDX_WORD0: sel_word = band_word0(band);
      default:   sel_word = word0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      idx           <= IDX_WORD5;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        active <= 1'b1;
        idx    <= IDX_WORD5;
      end else if (finishing) begin
        active <= 1'b0;
      end else if (out_load) begin
        idx <= idx + 1'b1;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      band  <= in_band;
      word0 <= in_word0;
    end
    if (out_load) begin
      m_axis_tdata <= sel_word;
      m_axis_tuser <= idx;
      m_axis_tlast <= (idx == IDX_COMPUTED);
    end
  end

endmodule

// ===== rtl/core/pll_band_select_register_words_unit.sv =====
// Turns a target frequency (whole MHz plus a kHz offset) into the seven
// 32-bit synthesizer register words: configured word 5, the output band's
// word 4, configured words 3 down to 1, the band's fixed word 0, then the
// computed word 0 with integer and fraction fields, tagged 0 to 6 in tuser
// and marked by tlast on the seventh. The output register sends one word
// per cycle while tready is high, and the word sequencer takes the next
// item as the last word of the one before is loaded; the arithmetic runs
// in a three-stage pipeline ahead of the word sequencer. Configuration
// writes land at once and must be made while idle.
module pll_band_select_register_words_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // freq_mhz [12:0], freq_khz [28:13], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // reg_word [31:0]
  output logic [2:0]  m_axis_tuser,   // word_index [2:0]
  output logic        m_axis_tlast
);
  import pbsr_pkg::*;

  cfg_words_t         words;
  logic [SCALE_W-1:0] scale;
  logic               calc_valid;
  logic               calc_ready;
  band_t              calc_band;
  logic [WORD_W-1:0]  calc_word0;

  pbsr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .words     (words),
    .scale     (scale)
  );

  pbsr_calc u_calc (
    .clk       (clk),
    .rst       (rst),
    .scale     (scale),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .freq_mhz  (s_axis_tdata[MHZ_W-1:0]),
    .freq_khz  (s_axis_tdata[MHZ_W+KHZ_W-1:MHZ_W]),
    .out_valid (calc_valid),
    .out_ready (calc_ready),
    .out_band  (calc_band),
    .out_word0 (calc_word0)
  );

  pbsr_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .words         (words),
    .in_valid      (calc_valid),
    .in_ready      (calc_ready),
    .in_band       (calc_band),
    .in_word0      (calc_word0),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== sim/pll_band_select_register_words_unit_test.sv =====
`timescale 1ns / 1ps

module pll_band_select_register_words_unit_test;
  import pbsr_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int ITEMS_PER_PHASE = 55;
  localparam int PHASES = 8;
  localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REG_SPARE_LAST = 3'd7;
  localparam logic [MHZ_W-1:0] TOP_MHZ = 13'd4400;
  localparam logic [MHZ_W-1:0] BAND_EDGES [4] = '{EDGE_DIV8, EDGE_DIV4, EDGE_DIV2, EDGE_DIV1};
  localparam logic [WORD_W-1:0] DIV_WORD4 [5] = '{32'h00C0_4024, 32'h00B0_4024,
                                                  32'h00A0_4024, 32'h0090_4024,
                                                  32'h0080_4024};
  localparam logic [WORD_W-1:0] DIV_WORD0 [5] = '{32'h0FA0_0000, 32'h0FA0_0000,
                                                  32'h0FA0_0000, 32'h1068_0000,
                                                  32'h08FC_0000};
  localparam logic [SCALE_W-1:0] PHASE_SCALE [PHASES] = '{3'd1, 3'd4, 3'd0, 3'd7,
                                                          3'd5, 3'd6, 3'd3, 3'd2};

  typedef struct {
    logic [WORD_W-1:0] word;
    logic [IDX_W-1:0]  index;
    logic              last;
  } reg_word_t;

  class register_word_board;
    logic [WORD_W-1:0]  word_one = RESET_WORD_ONE;
    logic [WORD_W-1:0]  word_two = RESET_WORD_TWO;
    logic [WORD_W-1:0]  word_three = RESET_WORD_THREE;
    logic [WORD_W-1:0]  word_five = RESET_WORD_FIVE;
    logic [SCALE_W-1:0] scale = RESET_SCALE;
    reg_word_t          pending_words[$];
    int                 faults = 0;

    function void apply_reg(input logic [2:0] idx, input logic [31:0] data);
      case (idx)
        REG_WORD_ONE:   word_one = data;
        REG_WORD_TWO:   word_two = data;
        REG_WORD_THREE: word_three = data;
        REG_WORD_FIVE:  word_five = data;
        REG_PFD_SCALE:  scale = data[SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_word(input logic [WORD_W-1:0] w, input logic [IDX_W-1:0] idx);
      reg_word_t e;
      e.word = w;
      e.index = idx;
      e.last = (idx == IDX_COMPUTED);
      pending_words.push_back(e);
    endfunction

    function void note_freq(input logic [MHZ_W-1:0] mhz, input logic [KHZ_W-1:0] khz);
      int band;
      longint unsigned mult, prod, quot, whole, frac;
      logic [WORD_W-1:0] computed;
      band = 0;
      for (int i = 0; i < 4; i++) begin
        if (mhz >= BAND_EDGES[i]) band++;
      end
      mult = longint'(scale) * (longint'(16) >> band);
      prod = mult * khz;
      quot = prod / 1000;
      whole = mult * mhz + quot;
      frac = prod - quot * 1000;
      computed = WORD_W'(8 * frac + 32768 * whole);
      push_word(word_five, IDX_WORD5);
      push_word(DIV_WORD4[band], IDX_WORD4);
      push_word(word_three, IDX_WORD3);
      push_word(word_two, IDX_WORD2);
      push_word(word_one, IDX_WORD1);
      push_word(DIV_WORD0[band], IDX_WORD0);
      push_word(computed, IDX_COMPUTED);
    endfunction

    function void check_word(input logic [WORD_W-1:0] w, input logic [IDX_W-1:0] idx,
                             input logic last);
      reg_word_t e;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word %h index %0d last %b", $time, w, idx, last);
        faults++;
        return;
      end
      e = pending_words.pop_front();
      if (w !== e.word) begin
        $display("%0t: reg_word expected %h got %h", $time, e.word, w);
        faults++;
      end
      if (idx !== e.index) begin
        $display("%0t: word_index expected %0d got %0d", $time, e.index, idx);
        faults++;
      end
      if (last !== e.last) begin
        $display("%0t: last_word expected %b got %b", $time, e.last, last);
        faults++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  register_word_board sb;
  logic steady;
  int   idle_cycles = 0;

  pll_band_select_register_words_unit uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // The watchdog counts cycles in which no transaction happens on either side.
  always @(posedge clk) begin
    if (rst === 1'b1 || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic receive_words();
    int stall;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
      @(negedge clk);
    end
  endtask

  task automatic send_freq(input logic [MHZ_W-1:0] mhz, input logic [KHZ_W-1:0] khz);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata = {3'b000, khz, mhz};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    sb.note_freq(mhz, khz);
    @(negedge clk);
  endtask

  task automatic send_random_freq();
    int pick;
    logic [MHZ_W-1:0] mhz;
    logic [KHZ_W-1:0] khz;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      mhz = MHZ_W'($urandom_range(0, TOP_MHZ));
      khz = KHZ_W'($urandom_range(0, 999));
    end else if (pick < 6) begin
      mhz = MHZ_W'(BAND_EDGES[$urandom_range(0, 3)] + $urandom_range(0, 2) - 1);
      khz = KHZ_W'($urandom);
    end else if (pick < 8) begin
      mhz = MHZ_W'($urandom_range(0, TOP_MHZ));
      khz = KHZ_W'($urandom);
    end else begin
      mhz = MHZ_W'($urandom);
      khz = KHZ_W'($urandom);
    end
    send_freq(mhz, khz);
  endtask

  task automatic wait_drained();
    while (sb.pending_words.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.apply_reg(idx, data);
  endtask

  task automatic configure_phase(input int phase);
    logic [31:0] fill [4];
    case (phase % 4)
      0: fill = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
      1: fill = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      2: fill = '{$urandom, $urandom, $urandom, $urandom};
      default: fill = '{32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA};
    endcase
    write_reg(REG_WORD_ONE, fill[0]);
    write_reg(REG_WORD_TWO, fill[1]);
    write_reg(REG_WORD_THREE, fill[2]);
    write_reg(REG_WORD_FIVE, fill[3]);
    write_reg(REG_PFD_SCALE, {29'($urandom_range(0, 32'h1FFF_FFFF)), PHASE_SCALE[phase]});
    for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++) begin
      write_reg(3'(i), $urandom);
    end
  endtask

  initial begin
    sb = new;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_WORD_ONE;
    cfg_data = 32'h0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 32'h0;
    m_axis_tready = 1'b0;
    steady = 1'b0;
    repeat (3) @(negedge clk);
    rst = 1'b0;
    fork
      receive_words();
    join_none

    send_freq(13'd0, 16'd0);
    send_freq(13'd274, 16'd999);
    send_freq(13'd275, 16'd1000);
    send_freq(13'd549, 16'd500);
    send_freq(13'd550, 16'd1);
    send_freq(13'd1099, 16'd65535);
    send_freq(13'd1100, 16'd250);
    send_freq(13'd2199, 16'd999);
    send_freq(13'd2200, 16'd0);
    send_freq(TOP_MHZ, 16'd999);
    send_freq(13'd4401, 16'd12345);
    send_freq(13'd8191, 16'd65535);
    send_freq(13'h1555, 16'hAAAA);
    send_freq(13'h0AAA, 16'h5555);
    steady = 1'b1;
    send_freq(13'd100, 16'd1999);
    send_freq(13'd3000, 16'd64000);
    send_freq(13'd800, 16'd0);
    steady = 1'b0;
    s_axis_tvalid = 1'b0;
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      configure_phase(p);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        steady = (i < 12);
        if (i == 30) begin
          s_axis_tvalid = 1'b0;
          wait_drained();
        end
        send_random_freq();
      end
      steady = 1'b0;
      s_axis_tvalid = 1'b0;
      wait_drained();
    end

    repeat (20) @(negedge clk);
    if (sb.faults == 0 && sb.pending_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
